>>> sv/bmsb_pkg.sv
`default_nettype none

package bmsb_pkg;

  localparam int CFG_BITS = 16;
  localparam int MODE_BITS = 2;

  localparam logic [1:0] REG_HOLD_TIME = 2'd0;
  localparam logic [1:0] REG_MODE_BEEP = 2'd1;
  localparam logic [1:0] REG_RESET_BEEP = 2'd2;
  localparam logic [1:0] REG_START_MODE = 2'd3;

  localparam logic [CFG_BITS-1:0] HOLD_TIME_RESET = 16'd3000;
  localparam logic [CFG_BITS-1:0] MODE_BEEP_RESET = 16'd200;
  localparam logic [CFG_BITS-1:0] RESET_BEEP_RESET = 16'd1000;

  localparam logic [MODE_BITS-1:0] MODE_ECO = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HYBRID = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_REMOTE = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_INVALID = 2'd3;

  typedef struct packed {
    logic button_pressed;
    logic wakeup_event;
  } tick_word_t;

  typedef struct packed {
    logic                 buzzer_on;
    logic [MODE_BITS-1:0] current_mode;
    logic                 commit_mode;
    logic                 factory_reset;
  } result_word_t;

  typedef struct packed {
    logic change_set;
    logic reset_set;
  } press_req_t;

  typedef struct packed {
    logic en;
    logic level;
  } buzz_wr_t;

  typedef struct packed {
    buzz_wr_t             buzz;
    logic                 commit;
    logic [MODE_BITS-1:0] mode;
  } mseq_out_t;

  typedef struct packed {
    buzz_wr_t buzz;
    logic     freset;
  } rseq_out_t;

  function automatic logic [MODE_BITS-1:0] next_mode(input logic [MODE_BITS-1:0] m);
    logic [MODE_BITS-1:0] r;
    case (m)
      MODE_ECO:    r = MODE_HYBRID;
      MODE_HYBRID: r = MODE_REMOTE;
      default:     r = MODE_ECO;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/bmsb_press.sv
`default_nettype none

module bmsb_press
  import bmsb_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                button,
  input  wire logic                wakeup,
  input  wire logic [CFG_BITS-1:0] hold_time,
  output press_req_t               req
);

  localparam logic [2:0] PRESS_IDLE = 3'd0;
  localparam logic [2:0] PRESS_HOLD = 3'd1;
  localparam logic [2:0] PRESS_LONG = 3'd2;
  localparam logic [2:0] PRESS_SHORT = 3'd3;
  localparam logic [2:0] PRESS_RELEASED = 3'd4;

  localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam logic [CMP_BITS-1:0] LIM = CMP_BITS'((64'd1 << TIMER_BITS) - 64'd2);

  logic [2:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;
  logic                  wake_pending, wake_pending_next, wake_eff;
  logic [CMP_BITS-1:0]   dur_c;
  logic                  expired;

  always_comb begin
    timer_inc = (timer == '1) ? timer : timer + 1'b1;
    dur_c = (CMP_BITS'(hold_time) > LIM) ? LIM : CMP_BITS'(hold_time);
    expired = CMP_BITS'(timer_inc) > dur_c;
  end

  always_comb begin
    wake_eff = wake_pending | wakeup;
    phase_next = phase;
    timer_next = timer;
    wake_pending_next = wake_eff;
    req = '0;
    case (phase)
      PRESS_IDLE: begin
        if (button || wake_eff) begin
          wake_pending_next = 1'b0;
          timer_next = '0;
          phase_next = PRESS_HOLD;
        end
      end
      PRESS_HOLD: begin
        timer_next = timer_inc;
        if (expired) phase_next = PRESS_LONG;
        if (!button) phase_next = PRESS_SHORT;
      end
      PRESS_LONG: begin
        req.reset_set = 1'b1;
        phase_next = PRESS_RELEASED;
      end
      PRESS_SHORT: begin
        req.change_set = 1'b1;
        phase_next = PRESS_RELEASED;
      end
      default: begin
        if (!button) phase_next = PRESS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PRESS_IDLE;
      timer <= '0;
      wake_pending <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      timer <= timer_next;
      wake_pending <= wake_pending_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/bmsb_mode_seq.sv
`default_nettype none

module bmsb_mode_seq
  import bmsb_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic                 change_set,
  input  wire logic [CFG_BITS-1:0]  beep_time,
  input  wire logic                 load,
  input  wire logic [MODE_BITS-1:0] load_mode,
  output mseq_out_t                 res
);

  localparam logic [2:0] MSEQ_IDLE = 3'd0;
  localparam logic [2:0] MSEQ_ON_START = 3'd1;
  localparam logic [2:0] MSEQ_ON_WAIT = 3'd2;
  localparam logic [2:0] MSEQ_OFF_START = 3'd3;
  localparam logic [2:0] MSEQ_OFF_WAIT = 3'd4;
  localparam logic [2:0] MSEQ_ADVANCE = 3'd5;

  localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam logic [CMP_BITS-1:0] LIM = CMP_BITS'((64'd1 << TIMER_BITS) - 64'd2);

  logic [2:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;
  logic [1:0]            beeps_left, beeps_left_next;
  logic                  change_request, change_request_next, change_eff;
  logic [MODE_BITS-1:0]  mode_value, mode_value_next;
  logic [CMP_BITS-1:0]   dur_c;
  logic                  expired;

  always_comb begin
    timer_inc = (timer == '1) ? timer : timer + 1'b1;
    dur_c = (CMP_BITS'(beep_time) > LIM) ? LIM : CMP_BITS'(beep_time);
    expired = CMP_BITS'(timer_inc) > dur_c;
  end

  always_comb begin
    change_eff = change_request | change_set;
    phase_next = phase;
    timer_next = timer;
    beeps_left_next = beeps_left;
    change_request_next = change_eff;
    mode_value_next = mode_value;
    res.buzz = '0;
    res.commit = 1'b0;
    case (phase)
      MSEQ_IDLE: begin
        if (change_eff) begin
          beeps_left_next = next_mode(mode_value) + 2'd1;
          phase_next = MSEQ_ON_START;
        end
      end
      MSEQ_ON_START: begin
        res.buzz = '{en: 1'b1, level: 1'b1};
        if (beeps_left != 2'd0) beeps_left_next = beeps_left - 2'd1;
        timer_next = '0;
        phase_next = MSEQ_ON_WAIT;
      end
      MSEQ_ON_WAIT: begin
        timer_next = timer_inc;
        if (expired) phase_next = MSEQ_OFF_START;
      end
      MSEQ_OFF_START: begin
        res.buzz = '{en: 1'b1, level: 1'b0};
        timer_next = '0;
        phase_next = MSEQ_OFF_WAIT;
      end
      MSEQ_OFF_WAIT: begin
        timer_next = timer_inc;
        if (expired) phase_next = MSEQ_ON_START;
        if (beeps_left == 2'd0) phase_next = MSEQ_ADVANCE;
      end
      default: begin
        mode_value_next = next_mode(mode_value);
        change_request_next = 1'b0;
        res.commit = 1'b1;
        phase_next = MSEQ_IDLE;
      end
    endcase
    res.mode = mode_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MSEQ_IDLE;
      timer <= '0;
      beeps_left <= 2'd0;
      change_request <= 1'b0;
      mode_value <= MODE_ECO;
    end else if (load) begin
      mode_value <= load_mode;
    end else if (accept) begin
      phase <= phase_next;
      timer <= timer_next;
      beeps_left <= beeps_left_next;
      change_request <= change_request_next;
      mode_value <= mode_value_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/bmsb_reset_seq.sv
`default_nettype none

module bmsb_reset_seq
  import bmsb_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                reset_set,
  input  wire logic [CFG_BITS-1:0] beep_time,
  output rseq_out_t                res
);

  localparam logic [2:0] RSEQ_IDLE = 3'd0;
  localparam logic [2:0] RSEQ_ON_START = 3'd1;
  localparam logic [2:0] RSEQ_ON_WAIT = 3'd2;
  localparam logic [2:0] RSEQ_OFF = 3'd3;
  localparam logic [2:0] RSEQ_PULSE = 3'd4;

  localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam logic [CMP_BITS-1:0] LIM = CMP_BITS'((64'd1 << TIMER_BITS) - 64'd2);

  logic [2:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;
  logic                  reset_request, reset_request_next, request_eff;
  logic [CMP_BITS-1:0]   dur_c;
  logic                  expired;

  always_comb begin
    timer_inc = (timer == '1) ? timer : timer + 1'b1;
    dur_c = (CMP_BITS'(beep_time) > LIM) ? LIM : CMP_BITS'(beep_time);
    expired = CMP_BITS'(timer_inc) > dur_c;
  end

  always_comb begin
    request_eff = reset_request | reset_set;
    phase_next = phase;
    timer_next = timer;
    reset_request_next = request_eff;
    res = '0;
    case (phase)
      RSEQ_IDLE: begin
        if (request_eff) phase_next = RSEQ_ON_START;
      end
      RSEQ_ON_START: begin
        res.buzz = '{en: 1'b1, level: 1'b1};
        timer_next = '0;
        phase_next = RSEQ_ON_WAIT;
      end
      RSEQ_ON_WAIT: begin
        timer_next = timer_inc;
        if (expired) phase_next = RSEQ_OFF;
      end
      RSEQ_OFF: begin
        res.buzz = '{en: 1'b1, level: 1'b0};
        timer_next = '0;
        phase_next = RSEQ_PULSE;
      end
      default: begin
        reset_request_next = 1'b0;
        res.freset = 1'b1;
        phase_next = RSEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= RSEQ_IDLE;
      timer <= '0;
      reset_request <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      timer <= timer_next;
      reset_request <= reset_request_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/button_mode_select_with_beeps_unit.sv
// A tick word's result is registered: into the output register, or into the skid entry when the output is held.
// Throughput: one tick word per cycle; a two-entry output buffer keeps ticks flowing
// while one result waits, and tick_stall rises only when both entries are full.
// Reset (rst, synchronous): all three machines idle, timers and requests clear,
// buzzer off, mode and configuration registers back to their default values.
`default_nettype none

module button_mode_select_with_beeps_unit
  import bmsb_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         tick_valid,
  output logic              tick_stall,
  input  wire tick_word_t   tick,
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_word_t      result,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CFG_BITS-1:0]  hold_time_ms, mode_beep_ms, reset_beep_ms;
  logic [MODE_BITS-1:0] start_mode, start_mode_wr;
  logic                 cfg_wr, mode_load;
  logic                 acc, out_take;
  press_req_t           req;
  mseq_out_t            mres;
  rseq_out_t            rres;
  logic                 buzzer_level, buzzer_next;
  result_word_t         word_next, skid;
  logic                 skid_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign start_mode_wr = (pwdata[1:0] == MODE_INVALID) ? MODE_REMOTE : pwdata[1:0];
  assign mode_load = cfg_wr && (paddr[3:2] == REG_START_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms <= HOLD_TIME_RESET;
      mode_beep_ms <= MODE_BEEP_RESET;
      reset_beep_ms <= RESET_BEEP_RESET;
      start_mode <= MODE_ECO;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HOLD_TIME:  hold_time_ms <= pwdata[CFG_BITS-1:0];
        REG_MODE_BEEP:  mode_beep_ms <= pwdata[CFG_BITS-1:0];
        REG_RESET_BEEP: reset_beep_ms <= pwdata[CFG_BITS-1:0];
        default:        start_mode <= start_mode_wr;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HOLD_TIME:  prdata = {16'd0, hold_time_ms};
      REG_MODE_BEEP:  prdata = {16'd0, mode_beep_ms};
      REG_RESET_BEEP: prdata = {16'd0, reset_beep_ms};
      default:        prdata = {30'd0, start_mode};
    endcase
  end

  assign tick_stall = skid_valid;
  assign acc = tick_valid & ~tick_stall;
  assign out_take = result_valid & ~result_stall;

  bmsb_press #(.TIMER_BITS(TIMER_BITS)) u_press (
    .clk       (clk),
    .rst       (rst),
    .accept    (acc),
    .button    (tick.button_pressed),
    .wakeup    (tick.wakeup_event),
    .hold_time (hold_time_ms),
    .req       (req)
  );

  bmsb_mode_seq #(.TIMER_BITS(TIMER_BITS)) u_mode_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (acc),
    .change_set (req.change_set),
    .beep_time  (mode_beep_ms),
    .load       (mode_load),
    .load_mode  (start_mode_wr),
    .res        (mres)
  );

  bmsb_reset_seq #(.TIMER_BITS(TIMER_BITS)) u_reset_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (acc),
    .reset_set (req.reset_set),
    .beep_time (reset_beep_ms),
    .res       (rres)
  );

  always_comb begin
    buzzer_next = buzzer_level;
    if (mres.buzz.en) buzzer_next = mres.buzz.level;
    if (rres.buzz.en) buzzer_next = rres.buzz.level;
    word_next.buzzer_on = buzzer_next;
    word_next.current_mode = mres.mode;
    word_next.commit_mode = mres.commit;
    word_next.factory_reset = rres.freset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer_level <= 1'b0;
    end else if (acc) begin
      buzzer_level <= buzzer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !result_valid) begin
      if (skid_valid) begin
        result <= skid;
        result_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (acc) begin
        result <= word_next;
        result_valid <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (acc) begin
      skid <= word_next;
      skid_valid <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a main result");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    (acc && !skid_valid && (!result_valid || !result_stall)) |=> result_valid)
    else $error("accepted word not offered");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.current_mode != MODE_INVALID))
    else $error("mode out of range");
`endif

endmodule

`default_nettype wire

>>> verif/button_mode_select_with_beeps_unit_tb.sv
module button_mode_select_with_beeps_unit_tb;
  import bmsb_pkg::*;

  typedef enum logic [2:0] {PR_IDLE, PR_HOLD, PR_LONG, PR_SHORT, PR_WAIT_RELEASE} press_st_e;
  typedef enum logic [2:0] {
    MB_IDLE, MB_ON_START, MB_ON_WAIT, MB_OFF_START, MB_OFF_WAIT, MB_ADVANCE
  } mode_beep_st_e;
  typedef enum logic [2:0] {RB_IDLE, RB_ON_START, RB_ON_WAIT, RB_OFF, RB_PULSE} reset_beep_st_e;

  typedef struct packed {
    logic         typed;
    tick_word_t   word;
    result_word_t want;
  } tick_entry_t;

  localparam logic [15:0] TMR_MAX = 16'hFFFF;
  localparam int DIRECTED_ROWS = 24;
  localparam int RECONF_ROW = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS = 310;
  localparam int PRESSURE_AT = 700;
  localparam int PRESSURE_CYCLES = 90;
  localparam int MAX_SHOWN = 10;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         tick_valid = 1'b0;
  logic         tick_stall;
  tick_word_t   tick = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  button_mode_select_with_beeps_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick        (tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // controller model state
  logic [15:0]    hold_ms;
  logic [15:0]    mbeep_ms;
  logic [15:0]    rbeep_ms;
  logic [1:0]     start_sel;
  press_st_e      press_st;
  logic [15:0]    press_cnt;
  logic           wake_latched;
  logic           change_req;
  logic           factory_req;
  mode_beep_st_e  mbeep_st;
  logic [15:0]    mbeep_cnt;
  logic [1:0]     beeps_todo;
  reset_beep_st_e rbeep_st;
  logic [15:0]    rbeep_cnt;
  logic [1:0]     mode_now;
  logic           buzz;

  tick_entry_t  tick_q[$];
  result_word_t pending_outputs[$];
  tick_entry_t  offered;
  result_word_t predicted;

  int tx_idle_pct = 13;
  int rx_stall_pct = 46;
  int rx_hold_left = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int commits_seen = 0;
  int resets_seen = 0;
  int input_stalls = 0;
  int reg_writes = 0;
  int mismatches = 0;

  tick_entry_t directed [DIRECTED_ROWS] = '{
    {1'b1, 1'b0, 1'b0, 1'b0, MODE_ECO, 1'b0, 1'b0},
    {1'b1, 1'b0, 1'b0, 1'b0, MODE_ECO, 1'b0, 1'b0},
    {1'b1, 1'b1, 1'b0, 1'b0, MODE_ECO, 1'b0, 1'b0},
    {1'b1, 1'b0, 1'b1, 1'b0, MODE_ECO, 1'b0, 1'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b1, 1'b1, 5'b0},
    {1'b0, 1'b1, 1'b0, 5'b0},
    {1'b0, 1'b1, 1'b0, 5'b0},
    {1'b0, 1'b1, 1'b0, 5'b0},
    {1'b0, 1'b1, 1'b0, 5'b0},
    {1'b0, 1'b1, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0},
    {1'b0, 1'b0, 1'b0, 5'b0}
  };

  function automatic logic [15:0] bump(input logic [15:0] t);
    return (t == TMR_MAX) ? TMR_MAX : t + 16'd1;
  endfunction

  function automatic logic elapsed(input logic [15:0] t, input logic [15:0] dur);
    logic [15:0] lim;
    lim = (dur > TMR_MAX - 16'd1) ? TMR_MAX - 16'd1 : dur;
    return t > lim;
  endfunction

  function automatic logic [1:0] following_mode(input logic [1:0] m);
    logic [1:0] n;
    case (m)
      MODE_ECO:    n = MODE_HYBRID;
      MODE_HYBRID: n = MODE_REMOTE;
      default:     n = MODE_ECO;
    endcase
    return n;
  endfunction

  task automatic clear_controller();
    hold_ms = HOLD_TIME_RESET;
    mbeep_ms = MODE_BEEP_RESET;
    rbeep_ms = RESET_BEEP_RESET;
    start_sel = MODE_ECO;
    press_st = PR_IDLE;
    press_cnt = '0;
    wake_latched = 1'b0;
    change_req = 1'b0;
    factory_req = 1'b0;
    mbeep_st = MB_IDLE;
    mbeep_cnt = '0;
    beeps_todo = '0;
    rbeep_st = RB_IDLE;
    rbeep_cnt = '0;
    mode_now = MODE_ECO;
    buzz = 1'b0;
  endtask

  task automatic set_controller_reg(input logic [1:0] idx, input logic [15:0] v);
    logic [1:0] m;
    m = v[1:0];
    case (idx)
      REG_HOLD_TIME:  hold_ms = v;
      REG_MODE_BEEP:  mbeep_ms = v;
      REG_RESET_BEEP: rbeep_ms = v;
      REG_START_MODE: begin
        if (m == MODE_INVALID) m = MODE_REMOTE;
        start_sel = m;
        mode_now = m;
      end
      default: begin
      end
    endcase
  endtask

  task automatic advance_controller(input tick_word_t w, output result_word_t r);
    logic commit;
    logic freset;
    commit = 1'b0;
    freset = 1'b0;
    if (w.wakeup_event) wake_latched = 1'b1;

    case (press_st)
      PR_IDLE: begin
        if (w.button_pressed || wake_latched) begin
          wake_latched = 1'b0;
          press_cnt = '0;
          press_st = PR_HOLD;
        end
      end
      PR_HOLD: begin
        press_cnt = bump(press_cnt);
        if (elapsed(press_cnt, hold_ms)) press_st = PR_LONG;
        if (!w.button_pressed) press_st = PR_SHORT;
      end
      PR_LONG: begin
        factory_req = 1'b1;
        press_st = PR_WAIT_RELEASE;
      end
      PR_SHORT: begin
        change_req = 1'b1;
        press_st = PR_WAIT_RELEASE;
      end
      default: begin
        if (!w.button_pressed) press_st = PR_IDLE;
      end
    endcase

    case (mbeep_st)
      MB_IDLE: begin
        if (change_req) begin
          beeps_todo = following_mode(mode_now) + 2'd1;
          mbeep_st = MB_ON_START;
        end
      end
      MB_ON_START: begin
        buzz = 1'b1;
        if (beeps_todo != 2'd0) beeps_todo = beeps_todo - 2'd1;
        mbeep_cnt = '0;
        mbeep_st = MB_ON_WAIT;
      end
      MB_ON_WAIT: begin
        mbeep_cnt = bump(mbeep_cnt);
        if (elapsed(mbeep_cnt, mbeep_ms)) mbeep_st = MB_OFF_START;
      end
      MB_OFF_START: begin
        buzz = 1'b0;
        mbeep_cnt = '0;
        mbeep_st = MB_OFF_WAIT;
      end
      MB_OFF_WAIT: begin
        mbeep_cnt = bump(mbeep_cnt);
        if (elapsed(mbeep_cnt, mbeep_ms)) mbeep_st = MB_ON_START;
        if (beeps_todo == 2'd0) mbeep_st = MB_ADVANCE;
      end
      default: begin
        mode_now = following_mode(mode_now);
        change_req = 1'b0;
        commit = 1'b1;
        mbeep_st = MB_IDLE;
      end
    endcase

    case (rbeep_st)
      RB_IDLE: begin
        if (factory_req) rbeep_st = RB_ON_START;
      end
      RB_ON_START: begin
        buzz = 1'b1;
        rbeep_cnt = '0;
        rbeep_st = RB_ON_WAIT;
      end
      RB_ON_WAIT: begin
        rbeep_cnt = bump(rbeep_cnt);
        if (elapsed(rbeep_cnt, rbeep_ms)) rbeep_st = RB_OFF;
      end
      RB_OFF: begin
        buzz = 1'b0;
        rbeep_cnt = '0;
        rbeep_st = RB_PULSE;
      end
      default: begin
        factory_req = 1'b0;
        freset = 1'b1;
        rbeep_st = RB_IDLE;
      end
    endcase

    r.buzzer_on = buzz;
    r.current_mode = mode_now;
    r.commit_mode = commit;
    r.factory_reset = freset;
  endtask

  task automatic report_mismatch(input string what, input result_word_t want,
                                 input result_word_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("mismatch at result %0d (%s): want buz=%b mode=%0d commit=%b freset=%b",
               results_seen, what, want.buzzer_on, want.current_mode, want.commit_mode,
               want.factory_reset);
      $display("  got buz=%b mode=%0d commit=%b freset=%b",
               got.buzzer_on, got.current_mode, got.commit_mode, got.factory_reset);
    end
  endtask

  task automatic check_output(input result_word_t got);
    result_word_t want;
    results_seen++;
    if (got.commit_mode === 1'b1) commits_seen++;
    if (got.factory_reset === 1'b1) resets_seen++;
    if (results_seen == PRESSURE_AT) rx_hold_left = PRESSURE_CYCLES;
    if (pending_outputs.size() == 0) begin
      report_mismatch("no word expected", '0, got);
    end else begin
      want = pending_outputs.pop_front();
      if (got.buzzer_on !== want.buzzer_on || got.current_mode !== want.current_mode ||
          got.commit_mode !== want.commit_mode || got.factory_reset !== want.factory_reset)
        report_mismatch("field", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (tick_valid && tick_stall) input_stalls++;
      if (tick_valid && !tick_stall) begin
        advance_controller(offered.word, predicted);
        pending_outputs.push_back(offered.typed ? offered.want : predicted);
        ticks_sent++;
      end
      if (!tick_valid || !tick_stall) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = tick_q.pop_front();
          tick <= offered.word;
          tick_valid <= 1'b1;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_output(result);
    if (rx_hold_left > 0) begin
      result_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    set_controller_reg(idx, v);
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] hold, input logic [15:0] mbeep,
                           input logic [15:0] rbeep, input logic [15:0] start);
    write_reg(REG_HOLD_TIME, hold);
    write_reg(REG_MODE_BEEP, mbeep);
    write_reg(REG_RESET_BEEP, rbeep);
    write_reg(REG_START_MODE, start);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || tick_valid || pending_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic add_ticks(input int count, input int btn_odds, input int wake_odds);
    tick_entry_t e;
    e = '0;
    repeat (count) begin
      e.word.button_pressed = ($urandom_range(99) < btn_odds);
      e.word.wakeup_event = ($urandom_range(99) < wake_odds);
      tick_q.push_back(e);
    end
  endtask

  // press episodes with random content, plus wake-only words and noise
  task automatic add_press_traffic(input int words);
    int made;
    int n;
    int gap;
    made = 0;
    while (made < words) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          n = $urandom_range(1, int'(hold_ms) + 1);
          add_ticks(n, 100, 6);
        end
        4, 5: begin
          n = int'(hold_ms) + $urandom_range(2, 5);
          add_ticks(n, 100, 6);
        end
        6: begin
          n = 1;
          add_ticks(n, 0, 100);
        end
        default: begin
          n = $urandom_range(1, 6);
          add_ticks(n, 50, 50);
        end
      endcase
      gap = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      add_ticks(gap, 0, 3);
      made += n + gap;
    end
  endtask

  initial begin
    int i;
    int p;
    clear_controller();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == RECONF_ROW) begin
        wait_drained();
        write_all(16'd2, 16'd1, 16'd1, {14'd0, MODE_HYBRID});
      end
      tick_q.push_back(directed[i]);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      tx_idle_pct = (p < 2) ? 13 : (p < 4) ? 46 : 0;
      rx_stall_pct = (p < 2) ? 46 : (p < 4) ? 13 : 0;
      case (p)
        1: write_all(16'd1, 16'd1, 16'd1, {14'd0, MODE_REMOTE});
        3: write_all(16'd0, 16'd0, 16'd0, {14'd0, MODE_INVALID});
        default: write_all(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                           16'($urandom_range(1, 5)), 16'($urandom_range(0, 3)));
      endcase
      add_press_traffic(PHASE_WORDS);
    end

    // saturate all durations, start a mode beep, then hold the button for a while
    wait_drained();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, {14'd0, MODE_REMOTE});
    add_ticks(1, 100, 0);
    add_ticks(3, 0, 0);
    add_ticks(40, 100, 0);
    add_ticks(40, 0, 0);

    wait_drained();
    repeat (4) @(negedge clk);
    if (pending_outputs.size() != 0) report_mismatch("left over", pending_outputs[0], '0);

    $display("covered %0d tick words and %0d result words over %0d register writes",
             ticks_sent, results_seen, reg_writes);
    $display("saw %0d mode commits, %0d factory resets, %0d stalled input cycles, %0d mismatches",
             commits_seen, resets_seen, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> button_mode_select_with_beeps_unit.f
sv/bmsb_pkg.sv
sv/bmsb_press.sv
sv/bmsb_mode_seq.sv
sv/bmsb_reset_seq.sv
sv/button_mode_select_with_beeps_unit.sv
verif/button_mode_select_with_beeps_unit_tb.sv
